### src/tq_pkg.sv
package tq_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int SUM_W    = CNT_W + 1;
	localparam int HANDLE_W = 10;
	localparam int TIME_W   = 32;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_ADJUST = 2'd1;
	localparam logic [1:0] MODE_DELETE = 2'd2;
	localparam logic [1:0] MODE_TICK   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_DUP      = 2'd3;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   expiry;
	} entry_t;

	typedef struct packed {
		logic             re;
		logic [IDX_W-1:0] raddr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
	} mem_req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic                expired_valid;
		logic [HANDLE_W-1:0] expired_handle;
		logic                last;
	} res_t;

	// Maps a position in sorted order to a slot of the circular store.
	function automatic logic [IDX_W-1:0] phys(logic [IDX_W-1:0] head, logic [CNT_W-1:0] ofs);
		logic [SUM_W-1:0] sum;
		sum = SUM_W'(head) + SUM_W'(ofs);
		if (sum >= SUM_W'(DEPTH))
			sum = sum - SUM_W'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

endpackage

### src/tq_mem.sv
module tq_mem
	import tq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rdata
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we)
			mem[req.waddr] <= req.wdata;
		if (req.re)
			rdata <= mem[req.raddr];
	end

endmodule

### src/tq_ctrl.sv
module tq_ctrl
	import tq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [TIME_W-1:0]   expiry,
	input  logic [TIME_W-1:0]   now,
	output mem_req_t            req,
	input  entry_t              rdata,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_SC_RD  = 4'd1;
	localparam logic [3:0] S_SC_EX  = 4'd2;
	localparam logic [3:0] S_DEC    = 4'd3;
	localparam logic [3:0] S_DN_RD  = 4'd4;
	localparam logic [3:0] S_DN_WR  = 4'd5;
	localparam logic [3:0] S_UP_RD  = 4'd6;
	localparam logic [3:0] S_UP_WR  = 4'd7;
	localparam logic [3:0] S_INS    = 4'd8;
	localparam logic [3:0] S_RES    = 4'd9;
	localparam logic [3:0] S_TK_RD  = 4'd10;
	localparam logic [3:0] S_TK_EX  = 4'd11;
	localparam logic [3:0] S_TK_FIN = 4'd12;

	logic [3:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [IDX_W-1:0]    head_q;
	logic [CNT_W-1:0]    j_q;
	logic [CNT_W-1:0]    slot_q;
	logic [CNT_W-1:0]    pos_q;
	logic                found_q;
	logic                posset_q;
	logic [1:0]          mode_q;
	logic [HANDLE_W-1:0] hnd_q;
	logic [TIME_W-1:0]   exp_q;
	logic [TIME_W-1:0]   now_q;
	logic [HANDLE_W-1:0] pend_q;
	logic                have_pend_q;
	logic [1:0]          st_q;

	logic expired;

	assign in_ready = (state_q == S_IDLE);
	assign expired  = (rdata.expiry <= now_q);

	always_comb begin
		req       = '0;
		res_valid = 1'b0;
		res       = '0;
		res.last  = 1'b1;
		unique case (state_q)
			S_SC_RD: begin
				req.re    = 1'b1;
				req.raddr = phys(head_q, j_q);
			end
			S_TK_RD: begin
				req.re    = 1'b1;
				req.raddr = head_q;
			end
			S_DN_RD: begin
				req.re    = (CNT_W'(j_q + 1'b1) < count_q);
				req.raddr = phys(head_q, CNT_W'(j_q + 1'b1));
			end
			S_DN_WR: begin
				req.we    = 1'b1;
				req.waddr = phys(head_q, j_q);
				req.wdata = rdata;
			end
			S_UP_RD: begin
				req.re    = (j_q != pos_q);
				req.raddr = phys(head_q, CNT_W'(j_q - 1'b1));
			end
			S_UP_WR: begin
				req.we    = 1'b1;
				req.waddr = phys(head_q, j_q);
				req.wdata = rdata;
			end
			S_INS: begin
				req.we           = 1'b1;
				req.waddr        = phys(head_q, pos_q);
				req.wdata.handle = hnd_q;
				req.wdata.expiry = exp_q;
			end
			S_RES: begin
				res_valid  = 1'b1;
				res.status = st_q;
			end
			S_TK_EX: begin
				res_valid          = expired && have_pend_q;
				res.status         = ST_OK;
				res.expired_valid  = 1'b1;
				res.expired_handle = pend_q;
				res.last           = 1'b0;
			end
			S_TK_FIN: begin
				res_valid          = 1'b1;
				res.status         = ST_OK;
				res.expired_valid  = have_pend_q;
				res.expired_handle = have_pend_q ? pend_q : '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			j_q         <= '0;
			slot_q      <= '0;
			pos_q       <= '0;
			found_q     <= 1'b0;
			posset_q    <= 1'b0;
			have_pend_q <= 1'b0;
			st_q        <= ST_OK;
			mode_q      <= MODE_ADD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q      <= mode;
						hnd_q       <= handle;
						exp_q       <= expiry;
						now_q       <= now;
						j_q         <= '0;
						found_q     <= 1'b0;
						posset_q    <= 1'b0;
						pos_q       <= count_q;
						have_pend_q <= 1'b0;
						st_q        <= ST_OK;
						if (mode == MODE_TICK)
							state_q <= (count_q == '0) ? S_TK_FIN : S_TK_RD;
						else
							state_q <= (count_q == '0) ? S_DEC : S_SC_RD;
					end
				end
				S_SC_RD: state_q <= S_SC_EX;
				S_SC_EX: begin
					if (rdata.handle == hnd_q) begin
						found_q <= 1'b1;
						slot_q  <= j_q;
					end else if (!posset_q && rdata.expiry > exp_q) begin
						posset_q <= 1'b1;
						pos_q    <= j_q;
					end
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= (CNT_W'(j_q + 1'b1) == count_q) ? S_DEC : S_SC_RD;
				end
				S_DEC: begin
					if (mode_q == MODE_ADD) begin
						if (found_q) begin
							st_q    <= ST_DUP;
							state_q <= S_RES;
						end else if (count_q == CNT_W'(DEPTH)) begin
							st_q    <= ST_FULL;
							state_q <= S_RES;
						end else begin
							j_q     <= count_q;
							state_q <= S_UP_RD;
						end
					end else if (!found_q) begin
						st_q    <= ST_NOTFOUND;
						state_q <= S_RES;
					end else begin
						if (pos_q > slot_q)
							pos_q <= CNT_W'(pos_q - 1'b1);
						j_q     <= slot_q;
						state_q <= S_DN_RD;
					end
				end
				S_DN_RD: begin
					if (CNT_W'(j_q + 1'b1) >= count_q) begin
						count_q <= CNT_W'(count_q - 1'b1);
						if (mode_q == MODE_ADJUST) begin
							j_q     <= CNT_W'(count_q - 1'b1);
							state_q <= S_UP_RD;
						end else begin
							state_q <= S_RES;
						end
					end else begin
						state_q <= S_DN_WR;
					end
				end
				S_DN_WR: begin
					j_q     <= CNT_W'(j_q + 1'b1);
					state_q <= S_DN_RD;
				end
				S_UP_RD: state_q <= (j_q == pos_q) ? S_INS : S_UP_WR;
				S_UP_WR: begin
					j_q     <= CNT_W'(j_q - 1'b1);
					state_q <= S_UP_RD;
				end
				S_INS: begin
					count_q <= CNT_W'(count_q + 1'b1);
					state_q <= S_RES;
				end
				S_RES: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				S_TK_RD: state_q <= S_TK_EX;
				S_TK_EX: begin
					if (!expired) begin
						state_q <= S_TK_FIN;
					end else if (!have_pend_q || res_ready) begin
						pend_q      <= rdata.handle;
						have_pend_q <= 1'b1;
						head_q      <= phys(head_q, CNT_W'(1));
						count_q     <= CNT_W'(count_q - 1'b1);
						state_q     <= (count_q == CNT_W'(1)) ? S_TK_FIN : S_TK_RD;
					end
				end
				S_TK_FIN: begin
					if (res_ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == $past(count_q) || count_q == CNT_W'($past(count_q) + 1'b1)
		|| CNT_W'(count_q + 1'b1) == $past(count_q))
		else $error("entry count moved by more than one");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.re && req.we))
		else $error("read and write issued in the same cycle");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !res_valid && !req.we)
		else $error("activity while idle");

endmodule

### src/sorted_timer_queue.sv
// Sorted timer queue: keeps up to DEPTH timers (handle, absolute expiry) in
// ascending expiry order in a single-port-style circular memory.
// Input channel (in_valid/in_ready, mode, handle, expiry, now) carries one
// command per transfer: add, adjust, delete or tick.
// Output channel (out_valid/out_ready, status, expired_valid, expired_handle,
// last) returns one result per add, adjust or delete, and for a tick one result
// per expired timer, head first, or one empty result when nothing expired.
// The final result of each command has last set.
// Commands are processed one at a time. A lookup scans all n stored entries,
// an insert or removal moves each displaced entry, and a tick pops each
// expired timer from the head. Results leave through an output register;
// a new command is taken while the last result still waits.
// When the receiver stalls, the block holds in its current step until the
// output register frees. Reset empties the queue at once; no clearing pass.
module sorted_timer_queue
	import tq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          mode,
	input  logic [HANDLE_W-1:0] handle,
	input  logic [TIME_W-1:0]   expiry,
	input  logic [TIME_W-1:0]   now,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                expired_valid,
	output logic [HANDLE_W-1:0] expired_handle,
	output logic                last
);

	mem_req_t req;
	entry_t   rdata;
	logic     res_valid;
	logic     res_ready;
	res_t     res;
	res_t     res_q;
	logic     out_valid_q;

	tq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.handle    (handle),
		.expiry    (expiry),
		.now       (now),
		.req       (req),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	tq_mem u_mem (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign expired_valid  = res_q.expired_valid;
	assign expired_handle = res_q.expired_handle;
	assign last           = res_q.last;

endmodule

### tb/sorted_timer_queue_tb.sv
`timescale 1ns / 1ps

module sorted_timer_queue_tb;
	import tq_pkg::*;

	class timer_table_checker;
		logic [TIME_W-1:0]   slot_expiry [DEPTH];
		logic [HANDLE_W-1:0] slot_handle [DEPTH];
		int                  count;
		res_t                due_results [$];
		int                  errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		function int find_handle(logic [HANDLE_W-1:0] h);
			for (int k = 0; k < count; k++) begin
				if (slot_handle[k] == h)
					return k;
			end
			return -1;
		endfunction

		function void remove_slot(int pos);
			for (int k = pos; k + 1 < count; k++) begin
				slot_expiry[k] = slot_expiry[k + 1];
				slot_handle[k] = slot_handle[k + 1];
			end
			count--;
		endfunction

		function void insert_sorted(logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] e);
			int pos;
			pos = 0;
			while (pos < count && slot_expiry[pos] <= e)
				pos++;
			for (int k = count; k > pos; k--) begin
				slot_expiry[k] = slot_expiry[k - 1];
				slot_handle[k] = slot_handle[k - 1];
			end
			slot_expiry[pos] = e;
			slot_handle[pos] = h;
			count++;
		endfunction

		function void note_command(logic [1:0] m, logic [HANDLE_W-1:0] h,
				logic [TIME_W-1:0] e, logic [TIME_W-1:0] n);
			res_t r;
			int   slot;
			int   hits;
			r = '0;
			r.last = 1'b1;
			if (m == MODE_TICK) begin
				hits = 0;
				while (count > 0 && slot_expiry[0] <= n) begin
					r.status = ST_OK;
					r.expired_valid = 1'b1;
					r.expired_handle = slot_handle[0];
					r.last = !(count > 1 && slot_expiry[1] <= n);
					remove_slot(0);
					due_results.push_back(r);
					hits++;
				end
				if (hits == 0)
					due_results.push_back(r);
				return;
			end
			slot = find_handle(h);
			if (m == MODE_ADD) begin
				if (slot >= 0)
					r.status = ST_DUP;
				else if (count >= DEPTH)
					r.status = ST_FULL;
				else
					insert_sorted(h, e);
			end else if (slot < 0) begin
				r.status = ST_NOTFOUND;
			end else begin
				remove_slot(slot);
				if (m == MODE_ADJUST)
					insert_sorted(h, e);
			end
			due_results.push_back(r);
		endfunction

		task check_result(res_t got);
			res_t want;
			if (due_results.size() == 0) begin
				report("result transfer with no result expected");
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status)
				report($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.expired_valid !== want.expired_valid)
				report($sformatf("expired_valid %0b, expected %0b",
					got.expired_valid, want.expired_valid));
			if (got.expired_handle !== want.expired_handle)
				report($sformatf("expired_handle %0d, expected %0d",
					got.expired_handle, want.expired_handle));
			if (got.last !== want.last)
				report($sformatf("last %0b, expected %0b", got.last, want.last));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          mode;
	logic [HANDLE_W-1:0] handle;
	logic [TIME_W-1:0]   expiry;
	logic [TIME_W-1:0]   now;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          status;
	logic                expired_valid;
	logic [HANDLE_W-1:0] expired_handle;
	logic                last;

	timer_table_checker sb = new();
	bit                 steady_flow;
	int                 hold_request;
	logic [TIME_W-1:0]  t_base;

	sorted_timer_queue u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.handle         (handle),
		.expiry         (expiry),
		.now            (now),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.expired_valid  (expired_valid),
		.expired_handle (expired_handle),
		.last           (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int draw_gap();
		if (steady_flow)
			return 0;
		return $urandom_range(0, 5);
	endfunction

	function automatic logic [HANDLE_W-1:0] pick_handle(int pct_present);
		if (sb.count > 0 && $urandom_range(0, 99) < pct_present)
			return sb.slot_handle[$urandom_range(0, sb.count - 1)];
		if ($urandom_range(0, 9) == 0)
			return HANDLE_W'($urandom);
		return HANDLE_W'($urandom_range(0, 31));
	endfunction

	// Called at a falling edge; returns at the falling edge after the transfer.
	task automatic offer_command(logic [1:0] m, logic [HANDLE_W-1:0] h,
			logic [TIME_W-1:0] e, logic [TIME_W-1:0] n);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		handle <= h;
		expiry <= e;
		now <= n;
		do @(posedge clk); while (!in_ready);
		sb.note_command(m, h, e, n);
		@(negedge clk);
	endtask

	initial begin
		res_t got;
		int   gap;
		@(posedge arst_n);
		forever begin
			if (hold_request > 0) begin
				out_ready <= 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.status = status;
			got.expired_valid = expired_valid;
			got.expired_handle = expired_handle;
			got.last = last;
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("sorted_timer_queue verification failed");
		$finish;
	end

	initial begin
		logic [1:0]          m;
		logic [HANDLE_W-1:0] h;
		logic [TIME_W-1:0]   e;
		logic [TIME_W-1:0]   n;
		int                  pick;
		int                  add_weight;
		int                  drain_wait;

		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_ADD;
		handle = '0;
		expiry = '0;
		now = '0;
		out_ready = 1'b0;
		steady_flow = 1'b0;
		hold_request = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty table: tick with nothing due, and lookups of absent handles.
		offer_command(MODE_TICK, '0, '0, '0);
		offer_command(MODE_DELETE, 10'd5, '0, '1);
		offer_command(MODE_ADJUST, 10'd5, 32'd9, '0);
		// Equal expiries keep arrival order; duplicate add; adjust both ways.
		offer_command(MODE_ADD, 10'd0, 32'd100, '0);
		offer_command(MODE_ADD, 10'd1023, 32'd100, '0);
		offer_command(MODE_ADD, 10'd0, 32'd7, '0);
		offer_command(MODE_ADJUST, 10'd0, 32'd200, '0);
		offer_command(MODE_ADJUST, 10'd0, 32'd0, '0);
		offer_command(MODE_DELETE, 10'd1023, '0, '0);
		// Fill the table, then a full add and a duplicate add while full.
		for (int k = 0; k < DEPTH - 1; k++) begin
			e = (k == DEPTH - 2) ? '1 : 32'd1000 + 32'(k / 3) * 32'd10;
			offer_command(MODE_ADD, HANDLE_W'(100 + k), e, '0);
		end
		offer_command(MODE_ADD, 10'd999, 32'd5, '0);
		offer_command(MODE_ADD, 10'd100, 32'd5, '0);
		// Everything expires at once.
		offer_command(MODE_TICK, '0, '0, '1);

		t_base = $urandom;
		for (int i = 0; i < 230; i++) begin
			steady_flow = (i >= 90 && i < 130);
			if (i == 60 || i == 170)
				hold_request = 200;
			if (i == 120) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (sb.due_results.size() != 0);
			end
			add_weight = ((i / 40) % 2) ? 55 : 30;
			pick = $urandom_range(0, 99);
			if (pick < add_weight)
				m = MODE_ADD;
			else if (pick < add_weight + 20)
				m = MODE_ADJUST;
			else if (pick < add_weight + 32)
				m = MODE_DELETE;
			else
				m = MODE_TICK;
			h = pick_handle((m == MODE_ADD) ? 10 : 75);
			if ($urandom_range(0, 9) == 0)
				e = $urandom;
			else
				e = t_base + $urandom_range(0, 60);
			n = $urandom;
			if (m == MODE_TICK) begin
				pick = $urandom_range(0, 9);
				if (pick == 1)
					n = '1;
				else if (pick > 1)
					n = t_base + $urandom_range(0, 40);
				t_base = t_base + $urandom_range(0, 15);
			end
			offer_command(m, h, e, n);
		end
		steady_flow = 1'b0;
		in_valid <= 1'b0;

		drain_wait = 0;
		while (sb.due_results.size() != 0 && drain_wait < 20000) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (150) @(negedge clk);
		if (sb.due_results.size() != 0)
			sb.report($sformatf("%0d expected results never arrived",
				sb.due_results.size()));
		if (sb.errors == 0)
			$display("sorted_timer_queue verification clean");
		else
			$display("sorted_timer_queue verification failed");
		$finish;
	end

endmodule
